FILE: rtl/frfc_pkg.sv
// Shared types, character codes and register indexes for the fiscal response
// frame checker. No dependencies; every other file of the block imports this one.
`default_nettype none

package frfc_pkg;

	// Width of the running byte sum kept inside the checker.
	localparam int SUM_BITS = 24;

	// Configuration write channel widths.
	localparam int CFG_IDX_BITS = 8;
	localparam int CFG_DATA_BITS = 16;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPECTED_CMD = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPECTED_SEQ = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WAITS = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_BUSY_CODE = CFG_IDX_BITS'(3);

	// Link control characters.
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_FS = 8'h1C;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_DC1 = 8'h11;
	localparam logic [7:0] CH_DC4 = 8'h14;

	// Checksum digit count, last tracked frame position and wait saturation.
	localparam logic [2:0] HEX_DIGITS = 3'd4;
	localparam logic [2:0] POS_LIMIT = 3'd4;
	localparam logic [15:0] WAIT_SAT = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_BODY,
		PH_SUM
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NO_FRAME,
		ST_CMD_MISMATCH,
		ST_NO_FS,
		ST_NO_ETX,
		ST_BAD_HEX,
		ST_SUM_MISMATCH
	} status_t;

	typedef struct packed {
		logic [7:0]  expected_cmd;
		logic [7:0]  expected_seq;
		logic [15:0] max_waits;
		logic [7:0]  busy_code;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		expected_cmd: 8'd42,
		expected_seq: 8'd32,
		max_waits:    16'd1000,
		busy_code:    8'd128
	};

	typedef struct packed {
		phase_t              phase;
		logic [2:0]          body_pos;
		logic [SUM_BITS-1:0] running_sum;
		logic [15:0]         hex_acc;
		logic [2:0]          digit_count;
		logic                seq_seen;
		logic                cmd_ok;
		logic                fs_ok;
		logic                hex_ok;
		logic [15:0]         wait_count;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:       PH_HUNT,
		body_pos:    3'd0,
		running_sum: '0,
		hex_acc:     16'd0,
		digit_count: 3'd0,
		seq_seen:    1'b0,
		cmd_ok:      1'b0,
		fs_ok:       1'b0,
		hex_ok:      1'b1,
		wait_count:  16'd0
	};

	typedef struct packed {
		status_t     status;
		logic [23:0] computed_sum;
		logic [15:0] received_sum;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/frfc_if.sv
// Handshake channel interfaces of the frame checker: input items, result items
// and configuration writes. Depends on frfc_pkg.
`default_nettype none

interface frfc_in_if
	import frfc_pkg::*;
	();
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface frfc_out_if
	import frfc_pkg::*;
	();
	logic        valid;
	logic        ready;
	status_t     status;
	logic [23:0] computed_sum;
	logic [15:0] received_sum;

	modport source (output valid, output status, output computed_sum,
		output received_sum, input ready);
	modport sink (input valid, input status, input computed_sum,
		input received_sum, output ready);
endinterface

interface frfc_cfg_if
	import frfc_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/frfc_core.sv
// Frame state register and its per-item update: hunt, body collection,
// checksum digits, timeout and status reporting. Depends on frfc_pkg.
`default_nettype none

module frfc_core
	import frfc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	input  wire logic    func,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t    cfg,
	output logic         fire,
	output result_t      res
);

	state_t     st_q;
	state_t     nx;
	logic       is_byte;
	logic [15:0] wc_inc;
	logic       expired;
	logic [4:0] digit;

	// Adds one byte to the running sum, wrapping at the sum width.
	function automatic state_t add_byte(state_t s, logic [7:0] b);
		state_t r;
		r = s;
		r.running_sum = s.running_sum + SUM_BITS'(b);
		return r;
	endfunction

	// Records a byte at the next frame position and checks the command and FS slots.
	function automatic state_t place(state_t s, logic [7:0] b, logic [7:0] cmd);
		state_t r;
		r = s;
		if (s.body_pos == 3'd2 && b == cmd) r.cmd_ok = 1'b1;
		if (s.body_pos == 3'd3 && b == CH_FS) r.fs_ok = 1'b1;
		if (s.body_pos < POS_LIMIT) r.body_pos = s.body_pos + 3'd1;
		return r;
	endfunction

	// Decodes an ASCII hex digit; bit 4 flags a character that is no digit.
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [4:0] r;
		r = {1'b1, 4'd0};
		if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
		return r;
	endfunction

	// Builds the status for a finished or timed-out frame.
	function automatic result_t frame_report(state_t s, logic etx_ok);
		result_t r;
		if (!s.cmd_ok) r.status = ST_CMD_MISMATCH;
		else if (!s.fs_ok) r.status = ST_NO_FS;
		else if (!etx_ok) r.status = ST_NO_ETX;
		else if (!s.hex_ok) r.status = ST_BAD_HEX;
		else if (SUM_BITS'(s.hex_acc) != s.running_sum) r.status = ST_SUM_MISMATCH;
		else r.status = ST_OK;
		r.computed_sum = 24'(s.running_sum);
		r.received_sum = s.hex_acc;
		return r;
	endfunction

	assign is_byte = !func;
	assign wc_inc = (st_q.wait_count != WAIT_SAT) ? st_q.wait_count + 16'd1 : st_q.wait_count;
	assign expired = wc_inc >= cfg.max_waits;
	assign digit = hex_digit(rx_byte);

	// Next state and result for the item at hand.
	always_comb begin
		nx = st_q;
		fire = 1'b0;
		res.status = ST_OK;
		res.computed_sum = '0;
		res.received_sum = '0;
		case (st_q.phase)
			PH_BODY: begin
				if (is_byte && rx_byte == CH_ETX) begin
					// ETX ends the body even before the sequence byte.
					nx = place(add_byte(st_q, rx_byte), rx_byte, cfg.expected_cmd);
					nx.phase = PH_SUM;
					nx.digit_count = 3'd0;
				end else begin
					// Bytes ahead of the sequence byte are dropped.
					if (is_byte && (st_q.seq_seen || rx_byte == cfg.expected_seq)) begin
						nx = place(add_byte(st_q, rx_byte), rx_byte, cfg.expected_cmd);
						nx.seq_seen = 1'b1;
					end
					nx.wait_count = wc_inc;
					if (expired) begin
						fire = 1'b1;
						res = frame_report(nx, 1'b0);
					end
				end
			end
			PH_SUM: begin
				if (is_byte) begin
					if (digit[4]) nx.hex_ok = 1'b0;
					nx.hex_acc = {st_q.hex_acc[11:0], digit[3:0]};
					nx = place(nx, rx_byte, cfg.expected_cmd);
					nx.digit_count = st_q.digit_count + 3'd1;
				end
				if (is_byte && nx.digit_count >= HEX_DIGITS) begin
					fire = 1'b1;
					res = frame_report(nx, 1'b1);
				end else begin
					nx.wait_count = wc_inc;
					if (expired) begin
						fire = 1'b1;
						res = frame_report(nx, 1'b0);
					end
				end
			end
			default: begin
				// Hunting for STX; any unused phase code behaves the same.
				nx.phase = PH_HUNT;
				if (is_byte && ((rx_byte >= CH_DC1 && rx_byte <= CH_DC4) ||
						rx_byte == CH_NAK || rx_byte == cfg.busy_code)) begin
					nx = st_q;
					nx.phase = PH_HUNT;
				end else if (is_byte && rx_byte == CH_STX) begin
					nx.phase = PH_BODY;
					nx.running_sum = SUM_BITS'(CH_STX);
					nx.body_pos = 3'd1;
					nx.seq_seen = 1'b0;
					nx.cmd_ok = 1'b0;
					nx.fs_ok = 1'b0;
					nx.hex_ok = 1'b1;
					nx.hex_acc = 16'd0;
					nx.digit_count = 3'd0;
					nx.wait_count = wc_inc;
					if (expired) begin
						fire = 1'b1;
						res = frame_report(nx, 1'b0);
					end
				end else begin
					nx.wait_count = wc_inc;
					if (expired) begin
						fire = 1'b1;
						res.status = ST_NO_FRAME;
					end
				end
			end
		endcase
		// Every report starts the next attempt from scratch.
		if (fire) nx = STATE_RESET;
	end

	// Frame state register, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (item_valid) begin
			st_q <= nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fiscal_response_frame_checker.sv
// Top level of the fiscal response frame checker: input register, config
// registers and result register around frfc_core. Depends on frfc_pkg, frfc_if.
//
//   channel  direction  handshake      payload
//   rx       in         valid/ready    func, rx_byte
//   res      out        valid/ready    status, computed_sum, received_sum
//   cfg      in         valid/ready    index, data (ready is always high)
//
// One item per cycle is sustained while no result waits at res; a result is
// registered as its item leaves the input stage, past the frame state update.
// Reset clears the frame state and the stage valid flags and returns the
// configuration to its reset values.
// A result waiting at res holds the input stage; one more item is taken into
// the input stage meanwhile, then rx.ready drops until res is taken.
`default_nettype none

module fiscal_response_frame_checker
	import frfc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	frfc_in_if.sink   rx,
	frfc_out_if.source res,
	frfc_cfg_if.sink  cfg
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       fire;
	result_t    step_res;
	logic       res_valid_q;
	result_t    res_q;

	// The input stage moves on whenever the result register can take a result.
	assign adv = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_EXPECTED_CMD: cfg_q.expected_cmd <= cfg.data[7:0];
				REG_EXPECTED_SEQ: cfg_q.expected_seq <= cfg.data[7:0];
				REG_MAX_WAITS:    cfg_q.max_waits <= cfg.data[15:0];
				REG_BUSY_CODE:    cfg_q.busy_code <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			func_s1 <= rx.func;
			byte_s1 <= rx.rx_byte;
		end
	end

	frfc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (adv),
		.func       (func_s1),
		.rx_byte    (byte_s1),
		.cfg        (cfg_q),
		.fire       (fire),
		.res        (step_res)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv && fire) begin
			res_q <= step_res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.status = res_q.status;
	assign res.computed_sum = res_q.computed_sum;
	assign res.received_sum = res_q.received_sum;

endmodule

`default_nettype wire

FILE: rtl/frfc_checker.sv
// Port-level assertions for the frame checker and the bind that attaches them
// to the top level. Depends on frfc_pkg and fiscal_response_frame_checker.
`default_nettype none

module frfc_checker
	import frfc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire status_t     status,
	input wire logic [23:0] computed_sum,
	input wire logic [15:0] received_sum
);

	// A result that is not taken stays offered unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) &&
		$stable(computed_sum) && $stable(received_sum))
		else $error("result changed while stalled");

	// A timeout while hunting carries no sums.
	a_no_frame_sums: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_NO_FRAME |-> computed_sum == 24'd0 &&
		received_sum == 16'd0)
		else $error("no-frame result carries sums");

	// A good frame has matching sums.
	a_ok_sums: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_OK |-> computed_sum == {8'd0, received_sum})
		else $error("ok result with unequal sums");

	// A good frame always starts with STX in its sum.
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_OK |-> received_sum != 16'd0)
		else $error("ok result with empty sum");

endmodule

bind fiscal_response_frame_checker frfc_checker u_frfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.status       (res.status),
	.computed_sum (res.computed_sum),
	.received_sum (res.received_sum)
);

`default_nettype wire
